### design/cmb_pkg.sv
// cmb_pkg: shared widths, register indexes and controller/datapath command types
// for the combination enumerator. No dependencies.
package cmb_pkg;

    localparam int MAX_CHOOSE_DEF = 8;
    localparam int MAX_SET_DEF    = 64;

    localparam int SET_W      = 7;
    localparam int CHOOSE_W   = 4;
    localparam int POS_W      = 3;
    localparam int ELEM_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = CFG_IDX_W'(1);

    localparam logic [SET_W-1:0]    SET_SIZE_RST     = SET_W'(8);
    localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RST = CHOOSE_W'(3);

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_LAST,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        CSEL_NONE,
        CSEL_INIT,
        CSEL_BUMP,
        CSEL_FILL
    } t_c_op;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_COMB,
        OUT_EXH
    } t_out_op;

    typedef struct packed {
        t_idx_op idx_op;
        t_c_op   c_op;
        t_out_op out_op;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic bad;
        logic grow;
        logic idx_zero;
        logic idx_last;
        logic slot_free;
    } t_status;

endpackage

### design/cmb_ifs.sv
// cmb_ifs: valid/ready channels of the combination enumerator (request, result, config)
// depends on cmb_pkg for field widths
interface cmb_in_if;
    import cmb_pkg::*;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface cmb_out_if;
    import cmb_pkg::*;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;
    logic              last_of_combination;
    logic              final_combination;
    logic              exhausted;

    modport source (output valid, output position, output element,
                    output last_of_combination, output final_combination,
                    output exhausted, input ready);
    modport sink (input valid, input position, input element,
                  input last_of_combination, input final_combination,
                  input exhausted, output ready);
endinterface

interface cmb_cfg_if;
    import cmb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/cmb_dpath.sv
// cmb_dpath: config registers, combination store, index counter and output register
// depends on cmb_pkg and cmb_ifs; driven by cmb_ctrl commands
module cmb_dpath #(
    parameter int MAX_CHOOSE = cmb_pkg::MAX_CHOOSE_DEF,
    parameter int MAX_SET    = cmb_pkg::MAX_SET_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cmb_pkg::t_cmd   i_cmd,
    output cmb_pkg::t_status o_status,
    cmb_cfg_if.sink         i_cfg,
    cmb_out_if.source       o_res
);
    import cmb_pkg::*;

    localparam int IW    = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
    localparam int PW    = $clog2(MAX_CHOOSE + 1);
    localparam int CW2   = (PW > CHOOSE_W) ? PW : CHOOSE_W;
    localparam int LIM_W = SET_W + 1;

    logic [SET_W-1:0]    r_set_size;
    logic [CHOOSE_W-1:0] r_choose;
    logic [ELEM_W-1:0]   r_c [MAX_CHOOSE];
    logic [IW-1:0]       r_idx;
    logic [ELEM_W-1:0]   r_val;
    logic                r_fin;

    logic              r_o_valid;
    logic [POS_W-1:0]  r_o_pos;
    logic [ELEM_W-1:0] r_o_elem;
    logic              r_o_last;
    logic              r_o_fin;
    logic              r_o_exh;

    logic [SET_W-1:0]  n_eff;
    logic [PW-1:0]     p_eff;
    logic [ELEM_W-1:0] c_rd;
    logic [LIM_W-1:0]  nmp;
    logic [LIM_W-1:0]  lim;
    logic              fin_now;
    logic              cfg_hit;
    logic              slot_free;
    logic              idx_last;

    assign n_eff = (r_set_size > SET_W'(MAX_SET)) ? SET_W'(MAX_SET) : r_set_size;
    assign p_eff = (CW2'(r_choose) > CW2'(MAX_CHOOSE)) ? PW'(MAX_CHOOSE) : PW'(r_choose);

    assign c_rd     = r_c[r_idx];
    assign nmp      = LIM_W'(n_eff) - LIM_W'(p_eff);
    assign lim      = nmp + LIM_W'(r_idx);
    assign idx_last = PW'(r_idx) == (p_eff - PW'(1));
    assign fin_now  = (r_idx == IW'(0)) ? (LIM_W'(c_rd) == nmp) : r_fin;

    assign cfg_hit   = i_cfg.valid && i_cfg.ready
                       && (i_cfg.index == REG_SET_SIZE || i_cfg.index == REG_CHOOSE_COUNT);
    assign slot_free = !r_o_valid || o_res.ready;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        o_status.cfg_wr    = cfg_hit;
        o_status.bad       = (p_eff == PW'(0)) || (LIM_W'(p_eff) > LIM_W'(n_eff));
        o_status.grow      = LIM_W'(c_rd) < lim;
        o_status.idx_zero  = r_idx == IW'(0);
        o_status.idx_last  = idx_last;
        o_status.slot_free = slot_free;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= SET_SIZE_RST;
            r_choose   <= CHOOSE_COUNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_SET_SIZE:     r_set_size <= i_cfg.data[SET_W-1:0];
                REG_CHOOSE_COUNT: r_choose   <= i_cfg.data[CHOOSE_W-1:0];
                default: ;
            endcase
        end
    end

    // combination store and walking index
    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IDX_ZERO: r_idx <= IW'(0);
            IDX_LAST: r_idx <= IW'(p_eff - PW'(1));
            IDX_INC:  r_idx <= r_idx + IW'(1);
            IDX_DEC:  r_idx <= r_idx - IW'(1);
            default:  r_idx <= r_idx;
        endcase

        case (i_cmd.c_op)
            CSEL_INIT: begin
                for (int i = 0; i < MAX_CHOOSE; i++) begin
                    r_c[i] <= ELEM_W'(i);
                end
            end
            CSEL_BUMP: begin
                r_c[r_idx] <= c_rd + ELEM_W'(1);
                r_val      <= c_rd + ELEM_W'(1);
            end
            CSEL_FILL: begin
                r_c[r_idx] <= r_val + ELEM_W'(1);
                r_val      <= r_val + ELEM_W'(1);
            end
            default: ;
        endcase

        if (i_cmd.out_op == OUT_COMB) begin
            r_fin <= fin_now;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_op != OUT_NONE) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end

        case (i_cmd.out_op)
            OUT_COMB: begin
                r_o_pos  <= POS_W'(r_idx);
                r_o_elem <= c_rd;
                r_o_last <= idx_last;
                r_o_fin  <= fin_now;
                r_o_exh  <= 1'b0;
            end
            OUT_EXH: begin
                r_o_pos  <= '0;
                r_o_elem <= '0;
                r_o_last <= 1'b0;
                r_o_fin  <= 1'b0;
                r_o_exh  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_res.valid               = r_o_valid;
    assign o_res.position            = r_o_pos;
    assign o_res.element             = r_o_elem;
    assign o_res.last_of_combination = r_o_last;
    assign o_res.final_combination   = r_o_fin;
    assign o_res.exhausted           = r_o_exh;

endmodule

### design/cmb_ctrl.sv
// cmb_ctrl: request sequencer for the combination enumerator (scan, fill, emit)
// depends on cmb_pkg and cmb_ifs; steers cmb_dpath by command struct
module cmb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cmb_in_if.sink           i_req,
    input  cmb_pkg::t_status i_status,
    output cmb_pkg::t_cmd    o_cmd
);
    import cmb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_EMIT,
        S_EXH
    } t_state;

    t_state r_state, n_state;
    logic   r_primed, n_primed;
    logic   r_done, n_done;
    logic   accept;

    assign i_req.ready = r_state == S_IDLE;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state      = r_state;
        n_primed     = r_primed;
        n_done       = r_done;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.c_op   = CSEL_NONE;
        o_cmd.out_op = OUT_NONE;

        case (r_state)
            S_IDLE: begin
                if (i_status.cfg_wr) begin
                    n_primed = 1'b0;
                end
                if (accept) begin
                    if (i_req.restart || !r_primed) begin
                        n_primed = 1'b1;
                        if (i_status.bad) begin
                            n_done  = 1'b1;
                            n_state = S_EXH;
                        end else begin
                            n_done       = 1'b0;
                            o_cmd.c_op   = CSEL_INIT;
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_EMIT;
                        end
                    end else if (r_done) begin
                        n_state = S_EXH;
                    end else begin
                        o_cmd.idx_op = IDX_LAST;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // walk down to the rightmost element that can still grow
                if (i_status.grow) begin
                    o_cmd.c_op = CSEL_BUMP;
                    if (i_status.idx_last) begin
                        o_cmd.idx_op = IDX_ZERO;
                        n_state      = S_EMIT;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                        n_state      = S_FILL;
                    end
                end else if (i_status.idx_zero) begin
                    n_done  = 1'b1;
                    n_state = S_EXH;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_FILL: begin
                o_cmd.c_op = CSEL_FILL;
                if (i_status.idx_last) begin
                    o_cmd.idx_op = IDX_ZERO;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.out_op = OUT_COMB;
                    o_cmd.idx_op = IDX_INC;
                    if (i_status.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EXH: begin
                if (i_status.slot_free) begin
                    o_cmd.out_op = OUT_EXH;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_primed <= n_primed;
            r_done   <= n_done;
        end
    end

endmodule

### design/combination_enumerator.sv
// combination_enumerator: lexicographic k-of-n combination generator, top level
// depends on cmb_pkg, cmb_ifs, cmb_ctrl and cmb_dpath
//
//   port     dir   word                                         rule
//   i_req    in    restart                                      valid & ready
//   o_res    out   position, element, last_of_combination,      valid & ready
//                  final_combination, exhausted
//   i_cfg    in    index (0 set_size, 1 choose_count), data     valid & ready, ready held high
//
// one request at a time; a restart loads the first combination and then emits it; an advance
// scans right to left for an element that can grow, refills the tail after it and then emits;
// an exhausted reply goes out when the walk is already done or the scan finds nothing left to grow;
// p words leave one a cycle from the output register while it is not stalled.
// synchronous active-low reset clears control state; the store holds no reset values.
// a stalled output holds the emit walk in place; requests wait until the walk ends.
module combination_enumerator #(
    parameter int MAX_CHOOSE = cmb_pkg::MAX_CHOOSE_DEF,
    parameter int MAX_SET    = cmb_pkg::MAX_SET_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmb_in_if.sink    i_req,
    cmb_out_if.source o_res,
    cmb_cfg_if.sink   i_cfg
);
    import cmb_pkg::*;

    t_cmd    cmd;
    t_status status;

    cmb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cmb_dpath #(
        .MAX_CHOOSE (MAX_CHOOSE),
        .MAX_SET    (MAX_SET)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_cfg    (i_cfg),
        .o_res    (o_res)
    );

endmodule
